// ===== src/ntc_adc_to_temperature_core_macros.svh =====
// ----------------------------------------------------------------------------
// NTC temperature core assertion macros
// Immediate-implication and next-cycle-implication checks on one clock.
// ----------------------------------------------------------------------------
`ifndef NTC_ADC_TO_TEMPERATURE_CORE_MACROS_SVH
`define NTC_ADC_TO_TEMPERATURE_CORE_MACROS_SVH

`ifndef SYNTH
`define NTCAT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ntcat check failed");
`define NTCAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ntcat check failed");
`else
`define NTCAT_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define NTCAT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/ntcat_pkg.sv =====
// ----------------------------------------------------------------------------
// ntcat_pkg
// Shared constants, command/status types and states of the NTC temperature core.
// ----------------------------------------------------------------------------
`default_nettype none

package ntcat_pkg;

	localparam int unsigned SAMPLE_W   = 12;
	localparam int unsigned BETA_W     = 14;
	localparam int unsigned CENTI_W    = 16;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_BETA  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOWER = 2'd2;

	localparam logic [BETA_W-1:0]         BETA_RST      = 14'd3950;
	localparam logic signed [CENTI_W-1:0] UPPER_RST     = 16'sd5000;
	localparam logic signed [CENTI_W-1:0] LOWER_RST     = -16'sd3000;
	localparam logic signed [CENTI_W-1:0] LAST_GOOD_RST = 16'sd2500;

	localparam logic [SAMPLE_W-1:0] SUPPLY_MV      = 12'd3300;
	localparam logic [13:0]         PULLUP_R_OHMS  = 14'd10000;
	localparam logic [13:0]         NOMINAL_R_OHMS = 14'd10000;

	// log2 datapath: mantissa Q1.30, result Q24 with 5 integer bits
	localparam int unsigned M_W    = 31;
	localparam int unsigned FRAC_W = 24;
	localparam int unsigned K_W    = 5;
	localparam int unsigned LOG_W  = K_W + FRAC_W;
	localparam logic [K_W-1:0] K_START = 5'd30;
	localparam logic [4:0]     FRAC_TOP = 5'd23;

	localparam logic [23:0] LN2_Q24 = 24'd11629080;

	localparam logic [63:0] INV_T0_FULL = ((64'd20 << 40) + 64'd2981) / 64'd5963;
	localparam logic [31:0] INV_T0_Q40  = INV_T0_FULL[31:0];

	localparam int unsigned DIV_W     = 48;
	localparam int unsigned DEN_W     = 46;
	localparam int unsigned DIV_CNT_W = 6;
	localparam int unsigned INV_W     = 50;

	localparam logic [63:0]      HUNDRED_Q40_FULL = 64'd100 << 40;
	localparam logic [DIV_W-1:0] HUNDRED_Q40      = HUNDRED_Q40_FULL[DIV_W-1:0];
	localparam logic [INV_W-1:0] CENTI_K_OFFSET   = 50'd27315;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_REJECT,
		OP_MUL_A,
		OP_MUL_B,
		OP_NORM,
		OP_SQR,
		OP_DIFF,
		OP_LN,
		OP_DIV1,
		OP_INVT,
		OP_DIV2,
		OP_FINAL,
		OP_EMIT
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [4:0] bit_idx;
	} cmd_t;

	typedef struct packed {
		logic sample_ok;
		logic normed;
		logic div_busy;
		logic div_done;
		logic inv_pos;
		logic out_free;
	} sts_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MUL_A,
		ST_NORM_A,
		ST_SQR_A,
		ST_MUL_B,
		ST_NORM_B,
		ST_SQR_B,
		ST_DIFF,
		ST_LN,
		ST_DIV1,
		ST_WAIT1,
		ST_INVT,
		ST_CHK_INV,
		ST_DIV2,
		ST_WAIT2,
		ST_FINAL,
		ST_REJECT,
		ST_EMIT
	} state_t;

endpackage

`default_nettype wire

// ===== src/ntcat_if.sv =====
// ----------------------------------------------------------------------------
// ntcat channel interfaces
// Valid/ready channels for sample input and temperature output.
// ----------------------------------------------------------------------------
`default_nettype none

interface ntcat_in_if;
	logic                              valid;
	logic                              ready;
	logic [ntcat_pkg::SAMPLE_W-1:0]    sample_mv;

	modport source (output valid, output sample_mv, input ready);
	modport sink   (input valid, input sample_mv, output ready);
endinterface

interface ntcat_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [ntcat_pkg::CENTI_W-1:0] temperature_centi;
	logic                              ok;

	modport source (output valid, output temperature_centi, output ok, input ready);
	modport sink   (input valid, input temperature_centi, input ok, output ready);
endinterface

`default_nettype wire

// ===== src/ntcat_div.sv =====
// ----------------------------------------------------------------------------
// ntcat_div
// Radix-2 restoring divider, one quotient bit per cycle, 48 steps.
// ----------------------------------------------------------------------------
`default_nettype none

module ntcat_div (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	input  wire [ntcat_pkg::DIV_W-1:0]   num,
	input  wire [ntcat_pkg::DEN_W-1:0]   den,
	output logic                         busy,
	output logic                         done,
	output logic [ntcat_pkg::DIV_W-1:0]  quot
);

	logic [ntcat_pkg::DIV_W-1:0]     num_q;
	logic [ntcat_pkg::DEN_W-1:0]     den_q;
	logic [ntcat_pkg::DEN_W-1:0]     rem_q;
	logic [ntcat_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                            busy_q;
	logic                            done_q;
	logic [ntcat_pkg::DEN_W:0]       trial;
	logic                            fits;

	assign trial = {rem_q, num_q[ntcat_pkg::DIV_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= ntcat_pkg::DIV_CNT_W'(ntcat_pkg::DIV_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			// quotient bits shift in where dividend bits shift out
			rem_q <= fits ? ntcat_pkg::DEN_W'(trial - {1'b0, den_q})
			              : trial[ntcat_pkg::DEN_W-1:0];
			num_q <= {num_q[ntcat_pkg::DIV_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = num_q;

endmodule

`default_nettype wire

// ===== src/ntcat_dp.sv =====
// ----------------------------------------------------------------------------
// ntcat_dp
// Datapath: config registers, log2 unit, ln scaling, divider, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ntcat_dp (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire [ntcat_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire [ntcat_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire [ntcat_pkg::SAMPLE_W-1:0]    sample_mv,
	input  ntcat_pkg::cmd_t                  cmd,
	output ntcat_pkg::sts_t                  sts,
	ntcat_out_if.source                      out_ch
);

	logic [ntcat_pkg::BETA_W-1:0]          beta_q;
	logic signed [ntcat_pkg::CENTI_W-1:0]  upper_q;
	logic signed [ntcat_pkg::CENTI_W-1:0]  lower_q;
	logic signed [ntcat_pkg::CENTI_W-1:0]  last_good_q;

	logic [ntcat_pkg::SAMPLE_W-1:0]  v_q;
	logic [ntcat_pkg::M_W-1:0]       m_q;
	logic [ntcat_pkg::K_W-1:0]       k_q;
	logic [ntcat_pkg::LOG_W-1:0]     res_q;
	logic [ntcat_pkg::LOG_W-1:0]     la_q;
	logic [ntcat_pkg::LOG_W-1:0]     mag_q;
	logic                            neg_q;
	logic [ntcat_pkg::LOG_W-1:0]     ln_q;
	logic [ntcat_pkg::INV_W-1:0]     inv_q;
	logic signed [ntcat_pkg::CENTI_W-1:0] centi_q;
	logic                            good_q;

	logic                            out_valid_q;
	logic signed [ntcat_pkg::CENTI_W-1:0] out_temp_q;
	logic                            out_ok_q;

	logic [25:0]                     prod_x;
	logic [61:0]                     sq;
	logic [31:0]                     sq_hi;
	logic [53:0]                     ln_prod;
	logic [ntcat_pkg::INV_W-1:0]     inv_t0_ext;
	logic [ntcat_pkg::INV_W-1:0]     quot_ext;
	logic signed [ntcat_pkg::INV_W-1:0] centi_full;
	logic signed [ntcat_pkg::INV_W-1:0] upper_ext;
	logic signed [ntcat_pkg::INV_W-1:0] lower_ext;

	logic                            div_start;
	logic [ntcat_pkg::DIV_W-1:0]     div_num;
	logic [ntcat_pkg::DEN_W-1:0]     div_den;
	logic                            div_busy;
	logic                            div_done;
	logic [ntcat_pkg::DIV_W-1:0]     div_quot;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_q  <= ntcat_pkg::BETA_RST;
			upper_q <= ntcat_pkg::UPPER_RST;
			lower_q <= ntcat_pkg::LOWER_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ntcat_pkg::REG_BETA:  beta_q  <= cfg_data[ntcat_pkg::BETA_W-1:0];
				ntcat_pkg::REG_UPPER: upper_q <= cfg_data;
				ntcat_pkg::REG_LOWER: lower_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		prod_x = 26'(v_q) * 26'(ntcat_pkg::PULLUP_R_OHMS);
		if (cmd.op == ntcat_pkg::OP_MUL_B)
			prod_x = 26'(ntcat_pkg::SUPPLY_MV - v_q) * 26'(ntcat_pkg::NOMINAL_R_OHMS);
	end

	assign sq      = 62'(m_q) * 62'(m_q);
	assign sq_hi   = sq[61:30];
	assign ln_prod = 54'(mag_q) * 54'(ntcat_pkg::LN2_Q24) + 54'(1 << (ntcat_pkg::FRAC_W - 1));

	assign inv_t0_ext = ntcat_pkg::INV_W'(ntcat_pkg::INV_T0_Q40);
	assign quot_ext   = ntcat_pkg::INV_W'(div_quot);
	assign centi_full = $signed(quot_ext - ntcat_pkg::CENTI_K_OFFSET);
	assign upper_ext  = ntcat_pkg::INV_W'(upper_q);
	assign lower_ext  = ntcat_pkg::INV_W'(lower_q);

	// working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			ntcat_pkg::OP_LOAD: v_q <= sample_mv;
			ntcat_pkg::OP_MUL_A, ntcat_pkg::OP_MUL_B: begin
				m_q <= ntcat_pkg::M_W'(prod_x);
				k_q <= ntcat_pkg::K_START;
				if (cmd.op == ntcat_pkg::OP_MUL_B)
					la_q <= res_q;
			end
			ntcat_pkg::OP_NORM: begin
				if (m_q[ntcat_pkg::M_W-1]) begin
					res_q <= {k_q, {ntcat_pkg::FRAC_W{1'b0}}};
				end else if (m_q[ntcat_pkg::M_W-1 -: 4] == 4'd0) begin
					m_q <= {m_q[ntcat_pkg::M_W-5:0], 4'd0};
					k_q <= k_q - 5'd4;
				end else begin
					m_q <= {m_q[ntcat_pkg::M_W-2:0], 1'b0};
					k_q <= k_q - 5'd1;
				end
			end
			ntcat_pkg::OP_SQR: begin
				if (sq_hi[31]) begin
					m_q <= sq_hi[31:1];
					res_q[cmd.bit_idx] <= 1'b1;
				end else begin
					m_q <= sq_hi[30:0];
				end
			end
			ntcat_pkg::OP_DIFF: begin
				neg_q <= la_q < res_q;
				mag_q <= (la_q < res_q) ? res_q - la_q : la_q - res_q;
			end
			ntcat_pkg::OP_LN:   ln_q <= ln_prod[52:24];
			ntcat_pkg::OP_INVT: inv_q <= neg_q ? inv_t0_ext - quot_ext : inv_t0_ext + quot_ext;
			ntcat_pkg::OP_FINAL: centi_q <= centi_full[ntcat_pkg::CENTI_W-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			good_q <= 1'b0;
		end else if (cmd.op == ntcat_pkg::OP_REJECT) begin
			good_q <= 1'b0;
		end else if (cmd.op == ntcat_pkg::OP_FINAL) begin
			good_q <= (centi_full <= upper_ext) && (centi_full >= lower_ext);
		end
	end

	always_comb begin
		div_start = 1'b0;
		div_num   = {3'd0, ln_q, 16'd0};
		div_den   = ntcat_pkg::DEN_W'(beta_q);
		case (cmd.op)
			ntcat_pkg::OP_DIV1: div_start = 1'b1;
			ntcat_pkg::OP_DIV2: begin
				div_start = 1'b1;
				div_num   = ntcat_pkg::HUNDRED_Q40
				          + ntcat_pkg::DIV_W'(inv_q[ntcat_pkg::DEN_W-1:1]);
				div_den   = inv_q[ntcat_pkg::DEN_W-1:0];
			end
			default: ;
		endcase
	end

	ntcat_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quot   (div_quot)
	);

	// result register and last good value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			last_good_q <= ntcat_pkg::LAST_GOOD_RST;
		end else begin
			if (out_valid_q && out_ch.ready)
				out_valid_q <= 1'b0;
			if (cmd.op == ntcat_pkg::OP_EMIT) begin
				out_valid_q <= 1'b1;
				if (good_q)
					last_good_q <= centi_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == ntcat_pkg::OP_EMIT) begin
			out_temp_q <= good_q ? centi_q : last_good_q;
			out_ok_q   <= good_q;
		end
	end

	assign out_ch.valid             = out_valid_q;
	assign out_ch.temperature_centi = out_temp_q;
	assign out_ch.ok                = out_ok_q;

	always_comb begin
		sts.sample_ok = (v_q != '0) && (v_q < ntcat_pkg::SUPPLY_MV) && (beta_q != '0);
		sts.normed    = m_q[ntcat_pkg::M_W-1];
		sts.div_busy  = div_busy;
		sts.div_done  = div_done;
		sts.inv_pos   = !inv_q[ntcat_pkg::INV_W-1] && (inv_q != '0);
		sts.out_free  = !out_valid_q || out_ch.ready;
	end

endmodule

`default_nettype wire

// ===== src/ntcat_ctrl.sv =====
// ----------------------------------------------------------------------------
// ntcat_ctrl
// Sequencer for one sample: two log2 passes, ln scaling, two divisions, emit; or reject, then emit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ntc_adc_to_temperature_core_macros.svh"

module ntcat_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_ready,
	input  ntcat_pkg::sts_t  sts,
	output ntcat_pkg::cmd_t  cmd
);

	ntcat_pkg::state_t state_q, state_d;
	logic [4:0]        cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ntcat_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ntcat_pkg::ST_NORM_A || state_q == ntcat_pkg::ST_NORM_B)
				cnt_q <= ntcat_pkg::FRAC_TOP;
			else if (state_q == ntcat_pkg::ST_SQR_A || state_q == ntcat_pkg::ST_SQR_B)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ntcat_pkg::ST_IDLE:    if (in_valid) state_d = ntcat_pkg::ST_CHECK;
			ntcat_pkg::ST_CHECK:   state_d = sts.sample_ok ? ntcat_pkg::ST_MUL_A
			                                               : ntcat_pkg::ST_REJECT;
			ntcat_pkg::ST_MUL_A:   state_d = ntcat_pkg::ST_NORM_A;
			ntcat_pkg::ST_NORM_A:  if (sts.normed) state_d = ntcat_pkg::ST_SQR_A;
			ntcat_pkg::ST_SQR_A:   if (cnt_q == '0) state_d = ntcat_pkg::ST_MUL_B;
			ntcat_pkg::ST_MUL_B:   state_d = ntcat_pkg::ST_NORM_B;
			ntcat_pkg::ST_NORM_B:  if (sts.normed) state_d = ntcat_pkg::ST_SQR_B;
			ntcat_pkg::ST_SQR_B:   if (cnt_q == '0) state_d = ntcat_pkg::ST_DIFF;
			ntcat_pkg::ST_DIFF:    state_d = ntcat_pkg::ST_LN;
			ntcat_pkg::ST_LN:      state_d = ntcat_pkg::ST_DIV1;
			ntcat_pkg::ST_DIV1:    state_d = ntcat_pkg::ST_WAIT1;
			ntcat_pkg::ST_WAIT1:   if (sts.div_done) state_d = ntcat_pkg::ST_INVT;
			ntcat_pkg::ST_INVT:    state_d = ntcat_pkg::ST_CHK_INV;
			ntcat_pkg::ST_CHK_INV: state_d = sts.inv_pos ? ntcat_pkg::ST_DIV2
			                                             : ntcat_pkg::ST_REJECT;
			ntcat_pkg::ST_DIV2:    state_d = ntcat_pkg::ST_WAIT2;
			ntcat_pkg::ST_WAIT2:   if (sts.div_done) state_d = ntcat_pkg::ST_FINAL;
			ntcat_pkg::ST_FINAL:   state_d = ntcat_pkg::ST_EMIT;
			ntcat_pkg::ST_REJECT:  state_d = ntcat_pkg::ST_EMIT;
			ntcat_pkg::ST_EMIT:    if (sts.out_free) state_d = ntcat_pkg::ST_IDLE;
			default:               state_d = ntcat_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		cmd.op      = ntcat_pkg::OP_NONE;
		cmd.bit_idx = cnt_q;
		case (state_q)
			ntcat_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = ntcat_pkg::OP_LOAD;
			end
			ntcat_pkg::ST_MUL_A:                    cmd.op = ntcat_pkg::OP_MUL_A;
			ntcat_pkg::ST_MUL_B:                    cmd.op = ntcat_pkg::OP_MUL_B;
			ntcat_pkg::ST_NORM_A, ntcat_pkg::ST_NORM_B: cmd.op = ntcat_pkg::OP_NORM;
			ntcat_pkg::ST_SQR_A, ntcat_pkg::ST_SQR_B:   cmd.op = ntcat_pkg::OP_SQR;
			ntcat_pkg::ST_DIFF:                     cmd.op = ntcat_pkg::OP_DIFF;
			ntcat_pkg::ST_LN:                       cmd.op = ntcat_pkg::OP_LN;
			ntcat_pkg::ST_DIV1:                     cmd.op = ntcat_pkg::OP_DIV1;
			ntcat_pkg::ST_INVT:                     cmd.op = ntcat_pkg::OP_INVT;
			ntcat_pkg::ST_DIV2:                     cmd.op = ntcat_pkg::OP_DIV2;
			ntcat_pkg::ST_FINAL:                    cmd.op = ntcat_pkg::OP_FINAL;
			ntcat_pkg::ST_REJECT:                   cmd.op = ntcat_pkg::OP_REJECT;
			ntcat_pkg::ST_EMIT: if (sts.out_free)   cmd.op = ntcat_pkg::OP_EMIT;
			default: ;
		endcase
	end

	`NTCAT_ASSERT_NOW(a_emit_free, clk, arst_n, cmd.op == ntcat_pkg::OP_EMIT, sts.out_free)
	`NTCAT_ASSERT_NEXT(a_sqr_a_end, clk, arst_n, state_q == ntcat_pkg::ST_SQR_A && cnt_q == '0, state_q == ntcat_pkg::ST_MUL_B)
	`NTCAT_ASSERT_NOW(a_idle_div, clk, arst_n, state_q == ntcat_pkg::ST_IDLE, !sts.div_busy)

endmodule

`default_nettype wire

// ===== src/ntc_adc_to_temperature_core.sv =====
// ----------------------------------------------------------------------------
// ntc_adc_to_temperature_core
// NTC divider voltage to temperature via the beta equation, fixed point.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                         | handshake
//  in_ch    | in  | sample_mv[11:0]                 | valid/ready
//  out_ch   | out | temperature_centi[15:0], ok     | valid/ready
//  cfg      | in  | cfg_index[1:0], cfg_data[15:0]  | cfg_we, no stall
//
// One sample at a time: two log2 passes of 3 to 7 normalize steps plus 24
// squaring steps on the shared multiplier, then two divisions of 48 steps
// on the radix-2 divider. A sample that fails the input check skips the
// math and goes through its reject step to emit.
// The result waits in an output register; a stalled output holds the block
// in its emit step. Reset is asynchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module ntc_adc_to_temperature_core (
	input  wire                              clk,
	input  wire                              arst_n,
	ntcat_in_if.sink                         in_ch,
	ntcat_out_if.source                      out_ch,
	input  wire                              cfg_we,
	input  wire [ntcat_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire [ntcat_pkg::CFG_DATA_W-1:0]  cfg_data
);

	ntcat_pkg::cmd_t cmd;
	ntcat_pkg::sts_t sts;
	logic            in_ready;

	assign in_ch.ready = in_ready;

	ntcat_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ntcat_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample_mv (in_ch.sample_mv),
		.cmd       (cmd),
		.sts       (sts),
		.out_ch    (out_ch)
	);

endmodule

`default_nettype wire
